/* rtl/bitmap_range_engine_macros.svh */
// Assertion macros used by the bitmap range engine checker.
`ifndef BITMAP_RANGE_ENGINE_MACROS_SVH
`define BITMAP_RANGE_ENGINE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define BRE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bre_pkg.sv */
// Shared constants, codes and control types of the bitmap range engine.
`timescale 1ns / 1ps
`default_nettype none
package bre_pkg;

    localparam int NUM_WORDS  = 16;
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = 6;
    localparam int CAPACITY   = NUM_WORDS * WORD_BITS;
    localparam int CAP_W      = $clog2(CAPACITY + 1);
    localparam int END_W      = (CAP_W > 12) ? CAP_W : 12;
    localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    localparam int CMD_W      = 3;
    localparam int START_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_SET      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TEST_CLR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TEST_SET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FILL     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_EMPTY    = 3'd5;

    // Per-word operation carried out while sweeping a range
    localparam logic [1:0] OP_SET      = 2'd0;
    localparam logic [1:0] OP_CLR      = 2'd1;
    localparam logic [1:0] OP_TEST_CLR = 2'd2;
    localparam logic [1:0] OP_TEST_SET = 2'd3;

    typedef struct packed {
        logic load;     // latch a new command
        logic step;     // process the current word
        logic publish;  // copy the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic empty;    // nothing to sweep
        logic last;     // current word is the last of the range
        logic hit;      // test failed on the current word
    } t_dp_status;

endpackage
`default_nettype wire

/* rtl/bre_ctrl.sv */
// Controller state machine: input handshake, word sweep sequencing, result slot.
`timescale 1ns / 1ps
`default_nettype none
module bre_ctrl
    import bre_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    output logic            o_m_axis_tvalid,
    input  wire             i_m_axis_tready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       s_accept;
    logic       slot_free;

    assign o_s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free       = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        o_cmd.load    = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.publish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.step = !i_status.empty;
                if (i_status.empty || i_status.last || i_status.hit) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

/* rtl/bre_dp.sv */
// Datapath: bitmap words, range decode, per-word mask and result register.
`timescale 1ns / 1ps
`default_nettype none
module bre_dp
    import bre_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire [IN_DATA_W-1:0]   i_s_axis_tdata,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_status            o_status,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic [WORD_BITS-1:0]  r_flags [NUM_WORDS];
    logic [1:0]            r_op;
    logic                  r_empty;
    logic                  r_err;
    logic                  r_answer;
    logic [WORD_IDX_W-1:0] r_word;
    logic [WORD_IDX_W-1:0] r_first;
    logic [WORD_IDX_W-1:0] r_last;
    logic [BIT_W-1:0]      r_lo_bit;
    logic [BIT_W-1:0]      r_hi_bit;
    logic                  r_out_answer;
    logic                  r_out_err;

    logic [CMD_W-1:0]      in_cmd;
    logic [END_W-1:0]      in_start;
    logic [END_W-1:0]      end_raw;
    logic [END_W-1:0]      n_end;
    logic [END_W-1:0]      n_lo;
    logic [END_W-1:0]      n_endm1;
    logic [1:0]            n_op;
    logic                  n_err;
    logic                  n_noop;

    logic [WORD_BITS-1:0]  cur_word;
    logic [WORD_BITS-1:0]  mask;
    logic [BIT_W-1:0]      lb;
    logic [BIT_W-1:0]      hb;

    assign in_cmd   = i_s_axis_tdata[CMD_W-1:0];
    assign in_start = END_W'(i_s_axis_tdata[CMD_W +: START_W]);
    assign end_raw  = in_start + END_W'(i_s_axis_tdata[CMD_W+START_W +: COUNT_W]);

    // Command decode: whole-map commands become a full-range set or clear
    always_comb begin
        n_end  = END_W'(CAPACITY);
        n_lo   = '0;
        n_err  = 1'b0;
        n_noop = 1'b0;
        n_op   = OP_SET;
        unique case (in_cmd) inside
            CMD_SET, CMD_CLEAR, CMD_TEST_CLR, CMD_TEST_SET: begin
                if (end_raw > END_W'(CAPACITY)) begin
                    n_err = 1'b1;
                end else begin
                    n_end = end_raw;
                end
                n_lo = (in_start > n_end) ? n_end : in_start;
                n_op = in_cmd[1:0];
            end
            CMD_FILL: begin
                n_op = OP_SET;
            end
            CMD_EMPTY: begin
                n_op = OP_CLR;
            end
            default: begin
                n_noop = 1'b1;
            end
        endcase
    end

    assign n_endm1 = n_end - END_W'(1);

    assign cur_word = r_flags[r_word];
    assign lb       = (r_word == r_first) ? r_lo_bit : '0;
    assign hb       = (r_word == r_last) ? r_hi_bit : BIT_W'(WORD_BITS - 1);
    assign mask     = ({WORD_BITS{1'b1}} << lb)
                    & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hb));

    assign o_status.empty = r_empty;
    assign o_status.last  = (r_word == r_last);
    assign o_status.hit   = ((r_op == OP_TEST_CLR) && (|(cur_word & mask)))
                         || ((r_op == OP_TEST_SET) && (|(~cur_word & mask)));

    assign o_m_axis_tdata = {{(OUT_DATA_W - 2){1'b0}}, r_out_err, r_out_answer};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_flags[i] <= '0;
            end
        end else if (i_cmd.step) begin
            if (r_op == OP_SET) begin
                r_flags[r_word] <= cur_word | mask;
            end else if (r_op == OP_CLR) begin
                r_flags[r_word] <= cur_word & ~mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= n_op;
            r_err    <= n_err;
            r_answer <= 1'b1;
            r_empty  <= n_noop || (n_lo == n_end);
            r_word   <= n_lo[BIT_W +: WORD_IDX_W];
            r_first  <= n_lo[BIT_W +: WORD_IDX_W];
            r_last   <= n_endm1[BIT_W +: WORD_IDX_W];
            r_lo_bit <= n_lo[BIT_W-1:0];
            r_hi_bit <= n_endm1[BIT_W-1:0];
        end else if (i_cmd.step) begin
            r_word <= r_word + WORD_IDX_W'(1);
            if (o_status.hit) begin
                r_answer <= 1'b0;
            end
        end
        if (i_cmd.publish) begin
            r_out_answer <= r_answer;
            r_out_err    <= r_err;
        end
    end

endmodule
`default_nettype wire

/* rtl/bitmap_range_engine.sv */
// Top level of the bitmap range engine: controller plus datapath.
//
// Usage: a bitmap of NUM_WORDS x 64 flags, all clear after reset.
// Input stream (s_axis) carries one command per transaction: tdata holds
// cmd [2:0], start_index [12:3], count [23:13]. Commands set, clear, test
// all clear or test all set over a range, or fill or empty the whole map.
// Output stream (m_axis) returns one transaction per command: tdata bit 0
// is the answer (test result, 1 for non-test commands), bit 1 flags a range
// clipped at the capacity.
// Timing: the datapath sweeps one 64-bit word per cycle, over the words
// the range touches (all NUM_WORDS for fill and empty; none for an empty
// range or an unused code); tests stop at the first failing word. One
// command is in work at a time; tready comes back high the cycle after the
// result is loaded into the output register, so the next command is taken
// only after the previous result is published.
// Reset (synchronous, active low) clears the bitmap, drops the output valid
// and holds tready low.
// If the receiver stalls, the result holds in the output register; the next
// command is still accepted and swept, and waits before publishing.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_range_engine
    import bre_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire [IN_DATA_W-1:0]   i_s_axis_tdata,   // cmd, start_index, count
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata    // answer, range_error, zero pad
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    bre_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_status        (dp_status),
        .o_cmd           (dp_cmd)
    );

    bre_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

/* rtl/bre_checker.sv */
// Port-level checker of the bitmap range engine and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_range_engine_macros.svh"
module bre_checker
    import bre_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_s_axis_tvalid,
    input wire                  o_s_axis_tready,
    input wire                  o_m_axis_tvalid,
    input wire                  i_m_axis_tready,
    input wire [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic s_accept;
    logic out_stall;
    assign s_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    `BRE_ASSERT(a_out_hold, i_clk, i_rst_n,
                out_stall |=> o_m_axis_tvalid, "result dropped while stalled")
    `BRE_ASSERT(a_out_stable, i_clk, i_rst_n,
                out_stall |=> $stable(o_m_axis_tdata), "stalled result changed")
    `BRE_ASSERT(a_one_in_work, i_clk, i_rst_n,
                s_accept |=> !o_s_axis_tready, "second command taken during a sweep")
    `BRE_ASSERT(a_min_latency, i_clk, i_rst_n,
                s_accept |=> !$rose(o_m_axis_tvalid), "result appeared too early")
    `BRE_ASSERT_ALWAYS(a_no_ready_in_reset, i_clk,
                       !i_rst_n |-> !o_s_axis_tready, "input ready during reset")

endmodule

bind bitmap_range_engine bre_checker u_bre_checker (.*);
`default_nettype wire
